// ----- sv/sensor_radio_header_crc_check_defines.svh -----
// Assertion macros shared by the radio header CRC check block.
`ifndef SENSOR_RADIO_HEADER_CRC_CHECK_DEFINES_SVH
`define SENSOR_RADIO_HEADER_CRC_CHECK_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SRHCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SRHCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/srhcc_pkg.sv -----
// Types and constants shared by the radio header CRC check block.
package srhcc_pkg;

  localparam int unsigned HEADER_LEN = 7;
  localparam int unsigned HDR_BYTES  = HEADER_LEN - 1;

  localparam logic [7:0] CRC_FEEDBACK  = 8'h18;
  localparam logic [5:0] COUNT_MAX     = 6'd63;
  localparam logic [5:0] HEADER_LEN6   = 6'd7;
  localparam logic [2:0] VERSION_RESET = 3'd1;
  localparam logic [2:0] LAST_BIT      = 3'd7;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_BITS,
    S_DONE
  } state_t;

  // Commands from the sequencer to the CRC unit
  typedef struct packed {
    logic clear;
    logic load;
    logic pad;
    logic step;
  } crc_ctl_t;

  // Status from the sequencer to the top level
  typedef struct packed {
    logic ready;
    logic finish;
    logic pad_busy;
    logic idle;
  } seq_status_t;

endpackage

// ----- sv/srhcc_crc_unit.sv -----
// Bit-serial reflected CRC-8 unit: one feedback step per cycle while step is asserted.
module srhcc_crc_unit
  import srhcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  crc_ctl_t   ctl,
  input  logic [7:0] data_in,
  output logic [7:0] crc
);

  logic [7:0] data_sr;
  logic [7:0] crc_next;
  logic       fb;

  // One shift of the reflected CRC with the current data bit
  always_comb begin
    fb = crc[0] ^ data_sr[0];
    if (fb) begin
      crc_next = {1'b1, crc[7:1] ^ CRC_FEEDBACK[7:1]};
    end else begin
      crc_next = {1'b0, crc[7:1]};
    end
  end

  // Hold the running CRC
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      crc <= '0;
    end else if (ctl.step) begin
      crc <= crc_next;
    end
  end

  // Load a new byte or shift out the consumed bit
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data_sr <= ctl.pad ? 8'h00 : data_in;
    end else if (ctl.step) begin
      data_sr <= {1'b0, data_sr[7:1]};
    end
  end

endmodule

// ----- sv/srhcc_seq.sv -----
// Sequencer: steps the CRC unit through each byte and the zero padding.
module srhcc_seq
  import srhcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_fire,
  input  logic        in_last,
  input  logic        feed,
  input  logic [5:0]  pad_bytes,
  input  logic        out_free,
  output crc_ctl_t    ctl,
  output seq_status_t status
);

  state_t     state, state_next;
  logic [2:0] bit_cnt, bit_cnt_next;
  logic [5:0] pad_rem, pad_rem_next;
  logic       last_seen, last_seen_next;

  // Advance state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bit_cnt   <= '0;
      pad_rem   <= '0;
      last_seen <= 1'b0;
    end else begin
      state     <= state_next;
      bit_cnt   <= bit_cnt_next;
      pad_rem   <= pad_rem_next;
      last_seen <= last_seen_next;
    end
  end

  // Next state and unit commands
  always_comb begin
    state_next     = state;
    bit_cnt_next   = bit_cnt;
    pad_rem_next   = pad_rem;
    last_seen_next = last_seen;
    ctl            = '0;
    status         = '0;
    status.pad_busy = (pad_rem != '0);
    unique case (state)
      S_IDLE: begin
        status.ready = 1'b1;
        status.idle  = 1'b1;
        if (in_fire) begin
          if (feed) begin
            ctl.load       = 1'b1;
            state_next     = S_BITS;
            bit_cnt_next   = '0;
            last_seen_next = in_last;
            pad_rem_next   = in_last ? pad_bytes : 6'd0;
          end else if (in_last) begin
            state_next = S_DONE;
          end
        end
      end
      S_BITS: begin
        ctl.step     = 1'b1;
        bit_cnt_next = bit_cnt + 3'd1;
        if (bit_cnt == LAST_BIT) begin
          if (last_seen && (pad_rem != '0)) begin
            ctl.load     = 1'b1;
            ctl.pad      = 1'b1;
            pad_rem_next = pad_rem - 6'd1;
          end else if (last_seen) begin
            state_next = S_DONE;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          status.finish  = 1'b1;
          ctl.clear      = 1'b1;
          last_seen_next = 1'b0;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/sensor_radio_header_crc_check.sv -----
// Top level: radio packet header capture with bit-serial CRC-8 check.
// A byte inside CRC_SPAN is accepted, then takes 8 CRC bit steps; a later byte is only accepted.
// A final byte adds 8 * max(0, CRC_SPAN - length) padding steps before the result is issued.
// All CRC steps run in the single bit-serial CRC unit; input waits meanwhile.
// The result register frees the input side while a result waits on m_tready.
// Synchronous active-high rst clears all packet state and sets accepted_version to 1.
`include "sensor_radio_header_crc_check_defines.svh"

module sensor_radio_header_crc_check
  import srhcc_pkg::*;
#(
  parameter int CRC_SPAN = 33
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] packet_byte
  input  logic        s_tlast,   // end_of_packet
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] accepted, [1] crc_ok, [9:2] computed_crc, [10] binary_flag,
  // [18:11] sender_id, [26:19] dest_id, [34:27] last_hop_id, [42:35] child_id,
  // [46:43] command_kind, [54:47] subtype, [60:55] payload_len, [63:61] zero
  output logic [63:0] m_tdata
);

  localparam logic [5:0] SPAN6 = 6'(CRC_SPAN);

  logic [2:0]  accepted_version;
  logic [5:0]  byte_count;
  logic [7:0]  received_crc;
  logic [7:0]  header_store [HDR_BYTES];
  logic [5:0]  len_next;
  logic [5:0]  pad_bytes;
  logic        feed;
  logic        in_fire;
  logic        out_free;
  logic [7:0]  crc;
  logic [2:0]  hdr_idx;
  crc_ctl_t    ctl;
  seq_status_t status;

  logic        accepted;
  logic        crc_ok;
  logic [5:0]  payload_len;
  logic [63:0] result;

  assign s_tready = status.ready;
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign feed     = (byte_count < SPAN6);
  assign len_next = (byte_count < COUNT_MAX) ? byte_count + 6'd1 : byte_count;
  assign pad_bytes = (len_next < SPAN6) ? SPAN6 - len_next : 6'd0;
  assign hdr_idx  = byte_count[2:0] - 3'd1;

  // Hold the version register
  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_version <= VERSION_RESET;
    end else if (cfg_we) begin
      accepted_version <= cfg_wdata;
    end
  end

  // Count bytes and capture the received CRC and header
  always_ff @(posedge clk) begin
    if (rst || status.finish) begin
      byte_count   <= '0;
      received_crc <= '0;
      for (int i = 0; i < HDR_BYTES; i++) begin
        header_store[i] <= '0;
      end
    end else if (in_fire) begin
      byte_count <= len_next;
      if (byte_count == '0) begin
        received_crc <= s_tdata;
      end else if (byte_count < HEADER_LEN6) begin
        header_store[hdr_idx] <= s_tdata;
      end
    end
  end

  srhcc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_last   (s_tlast),
    .feed      (feed),
    .pad_bytes (pad_bytes),
    .out_free  (out_free),
    .ctl       (ctl),
    .status    (status)
  );

  srhcc_crc_unit u_crc (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .data_in ((byte_count == '0) ? 8'h00 : s_tdata),
    .crc     (crc)
  );

  // Assemble the result transaction
  always_comb begin
    accepted    = (byte_count >= HEADER_LEN6) &&
                  (header_store[0][2:0] == accepted_version);
    crc_ok      = (crc == received_crc);
    payload_len = (byte_count >= HEADER_LEN6) ? byte_count - HEADER_LEN6 : 6'd0;
    result = {3'b000,
              payload_len,
              header_store[5],
              header_store[4][7:4],
              header_store[4][3:0], header_store[3][7:4],
              header_store[3][3:0], header_store[2][7:4],
              header_store[2][3:0], header_store[1][7:4],
              header_store[1][3:0], header_store[0][7:4],
              header_store[0][3],
              crc,
              crc_ok,
              accepted};
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (status.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.finish) begin
      m_tdata <= result;
    end
  end

  `SRHCC_ASSERT_NOW(a_pad_idle, status.idle, !status.pad_busy, "padding count left at idle")
  `SRHCC_ASSERT_NEXT(a_last_busy, in_fire && s_tlast, !s_tready, "ready right after final byte")
  `SRHCC_ASSERT_NEXT(a_clear_done, status.finish, (byte_count == '0) && (crc == '0) && m_tvalid, "packet state not cleared on result")

endmodule
